/* rtl/core/ptd_pkg.sv */
// Shared definitions for the periodic task dispatcher.
// Holds default sizes, port widths and request operation codes.
// No dependencies.
package ptd_pkg;

  // Default table geometry
  localparam int DEF_TASK_SLOTS   = 16;
  localparam int DEF_TASK_ID_BITS = 16;

  // Fixed port widths
  localparam int OP_W      = 3;
  localparam int SLOT_W    = 8;
  localparam int ID_PORT_W = 16;
  localparam int TIME_W    = 32;

  // Request operation codes
  localparam logic [OP_W-1:0] OP_REGISTER  = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR_SLOT = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR_ID  = 3'd2;
  localparam logic [OP_W-1:0] OP_EN_SLOT   = 3'd3;
  localparam logic [OP_W-1:0] OP_EN_ID     = 3'd4;
  localparam logic [OP_W-1:0] OP_RUN       = 3'd5;

endpackage

/* rtl/core/periodic_task_dispatcher.sv */
// Periodic task dispatcher: top level with request sequencer and head update.
// Builds a ring of ptd_cell slots; depends on ptd_pkg and ptd_cell.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. It
//   carries operation, slot, task_id, interval_ms, enable and now_ms.
//   Every request rotates the slot ring once: each cycle the slot at the
//   head is inspected and updated, then passed to the tail. After
//   a full rotation the ring is back in slot order.
//   Results leave on status/fired/slot_index/fired_task_id/last, each valid
//   for one cycle while strobe is high. A run gives one fired result per
//   due slot during the rotation, in slot order, then one closing result
//   with last high. Every other operation gives a single result.
//   The closing result is taken at the edge where the next request can
//   also be taken, so the block takes no new request before it is
//   through with the last; each request is paced by the ring rotation
//   that visits each slot once.
//   The receiver cannot stall: results are presented once and not held.
//   Reset (synchronous) empties all slots and returns to idle.
module periodic_task_dispatcher #(
  parameter int TASK_SLOTS   = ptd_pkg::DEF_TASK_SLOTS,
  parameter int TASK_ID_BITS = ptd_pkg::DEF_TASK_ID_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ptd_pkg::OP_W-1:0]      operation,
  input  logic [ptd_pkg::SLOT_W-1:0]    slot,
  input  logic [ptd_pkg::ID_PORT_W-1:0] task_id,
  input  logic [ptd_pkg::TIME_W-1:0]    interval_ms,
  input  logic                          enable,
  input  logic [ptd_pkg::TIME_W-1:0]    now_ms,
  output logic                          strobe,
  output logic                          status,
  output logic                          fired,
  output logic [ptd_pkg::SLOT_W-1:0]    slot_index,
  output logic [ptd_pkg::ID_PORT_W-1:0] fired_task_id,
  output logic                          last
);

  localparam int CNT_BITS = $clog2(TASK_SLOTS + 1);
  localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(TASK_SLOTS - 1);
  localparam logic [ptd_pkg::SLOT_W-1:0] SLOT_LIMIT = ptd_pkg::SLOT_W'(TASK_SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;

  // Latched request
  logic [ptd_pkg::OP_W-1:0]     op_r;
  logic [ptd_pkg::SLOT_W-1:0]   slot_r;
  logic [TASK_ID_BITS-1:0]      id_r;
  logic [ptd_pkg::TIME_W-1:0]   interval_r;
  logic                         en_r;
  logic [ptd_pkg::TIME_W-1:0]   now_r;

  logic [CNT_BITS-1:0]          cnt;
  logic                         found;
  logic [CNT_BITS-1:0]          found_pos;

  // Ring wiring
  logic [TASK_ID_BITS-1:0]      ring_id   [TASK_SLOTS];
  logic                         ring_en   [TASK_SLOTS];
  logic [ptd_pkg::TIME_W-1:0]   ring_int  [TASK_SLOTS];
  logic [ptd_pkg::TIME_W-1:0]   ring_due  [TASK_SLOTS];

  logic [TASK_ID_BITS-1:0]      head_id;
  logic                         head_en;
  logic [ptd_pkg::TIME_W-1:0]   head_int;
  logic [ptd_pkg::TIME_W-1:0]   head_due;
  logic                         head_fire;
  logic                         head_found;
  logic                         shift;

  logic [31:0]                  id_wide;
  logic [31:0]                  fire_id_wide;
  logic                         slot_hit;
  logic                         id_hit;

  assign busy  = (state != ST_IDLE);
  assign shift = (state == ST_SCAN);

  // Request id trimmed or zero-extended to the stored width
  assign id_wide      = 32'(task_id);
  assign fire_id_wide = 32'(ring_id[0]);

  generate
    for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_slot
      if (i == TASK_SLOTS - 1) begin : g_tail
        ptd_cell #(.ID_BITS(TASK_ID_BITS)) u_cell (
          .clk         (clk),
          .rst         (rst),
          .shift       (shift),
          .nb_task_id  (head_id),
          .nb_enabled  (head_en),
          .nb_interval (head_int),
          .nb_due      (head_due),
          .task_id     (ring_id[i]),
          .enabled     (ring_en[i]),
          .interval    (ring_int[i]),
          .due         (ring_due[i])
        );
      end else begin : g_body
        ptd_cell #(.ID_BITS(TASK_ID_BITS)) u_cell (
          .clk         (clk),
          .rst         (rst),
          .shift       (shift),
          .nb_task_id  (ring_id[i+1]),
          .nb_enabled  (ring_en[i+1]),
          .nb_interval (ring_int[i+1]),
          .nb_due      (ring_due[i+1]),
          .task_id     (ring_id[i]),
          .enabled     (ring_en[i]),
          .interval    (ring_int[i]),
          .due         (ring_due[i])
        );
      end
    end
  endgenerate

  // Head slot update for the slot at position cnt
  assign slot_hit = (slot_r == ptd_pkg::SLOT_W'(cnt));
  assign id_hit   = !found && (ring_id[0] == id_r);

  always_comb begin
    head_id    = ring_id[0];
    head_en    = ring_en[0];
    head_int   = ring_int[0];
    head_due   = ring_due[0];
    head_fire  = 1'b0;
    head_found = 1'b0;
    case (op_r)
      ptd_pkg::OP_REGISTER: begin
        if (slot_hit) begin
          head_id  = id_r;
          head_en  = en_r;
          head_int = interval_r;
        end
      end
      ptd_pkg::OP_CLEAR_SLOT: begin
        if (slot_hit) begin
          head_id  = '0;
          head_en  = 1'b0;
          head_int = '0;
          head_due = '0;
        end
      end
      ptd_pkg::OP_CLEAR_ID: begin
        if (id_hit) begin
          head_id    = '0;
          head_en    = 1'b0;
          head_int   = '0;
          head_due   = '0;
          head_found = 1'b1;
        end
      end
      ptd_pkg::OP_EN_SLOT: begin
        if (slot_hit) begin
          head_en = en_r;
        end
      end
      ptd_pkg::OP_EN_ID: begin
        if (id_hit) begin
          head_en    = en_r;
          head_found = 1'b1;
        end
      end
      ptd_pkg::OP_RUN: begin
        if ((ring_id[0] != '0) && ring_en[0] && (now_r >= ring_due[0])) begin
          head_due  = now_r + ring_int[0];
          head_fire = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
      cnt    <= '0;
      found  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op_r       <= operation;
            slot_r     <= slot;
            id_r       <= id_wide[TASK_ID_BITS-1:0];
            interval_r <= interval_ms;
            en_r       <= enable;
            now_r      <= now_ms;
            cnt        <= '0;
            found      <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (head_found) begin
            found     <= 1'b1;
            found_pos <= cnt;
          end
          if (head_fire) begin
            strobe        <= 1'b1;
            status        <= 1'b0;
            fired         <= 1'b1;
            slot_index    <= ptd_pkg::SLOT_W'(cnt);
            fired_task_id <= fire_id_wide[ptd_pkg::ID_PORT_W-1:0];
            last          <= 1'b0;
          end
          cnt <= cnt + 1'b1;
          if (cnt == LAST_CNT) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          strobe        <= 1'b1;
          fired         <= 1'b0;
          fired_task_id <= '0;
          last          <= 1'b1;
          case (op_r) inside
            ptd_pkg::OP_REGISTER, ptd_pkg::OP_CLEAR_SLOT, ptd_pkg::OP_EN_SLOT: begin
              status     <= !(slot_r < SLOT_LIMIT);
              slot_index <= (slot_r < SLOT_LIMIT) ? slot_r : '0;
            end
            ptd_pkg::OP_CLEAR_ID, ptd_pkg::OP_EN_ID: begin
              status     <= !found;
              slot_index <= found ? ptd_pkg::SLOT_W'(found_pos) : '0;
            end
            ptd_pkg::OP_RUN: begin
              status     <= 1'b0;
              slot_index <= '0;
            end
            default: begin
              status     <= 1'b1;
              slot_index <= '0;
            end
          endcase
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/ptd_cell.sv */
// One task slot of the dispatcher ring: id, enable, interval and due time.
// On shift it loads the record handed over by its neighbor.
// Depends on ptd_pkg.
module ptd_cell #(
  parameter int ID_BITS = ptd_pkg::DEF_TASK_ID_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        shift,
  input  logic [ID_BITS-1:0]          nb_task_id,
  input  logic                        nb_enabled,
  input  logic [ptd_pkg::TIME_W-1:0]  nb_interval,
  input  logic [ptd_pkg::TIME_W-1:0]  nb_due,
  output logic [ID_BITS-1:0]          task_id,
  output logic                        enabled,
  output logic [ptd_pkg::TIME_W-1:0]  interval,
  output logic [ptd_pkg::TIME_W-1:0]  due
);

  // Slot record, empty after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      task_id  <= '0;
      enabled  <= 1'b0;
      interval <= '0;
      due      <= '0;
    end else if (shift) begin
      task_id  <= nb_task_id;
      enabled  <= nb_enabled;
      interval <= nb_interval;
      due      <= nb_due;
    end
  end

endmodule
